// File: rtl/core/lca_pkg.sv
// Shared constants, types and address helpers of the lowest-common-ancestor block.
package lca_pkg;

  localparam int NODE_W    = 10;
  localparam int DEPTH_W   = 10;
  localparam int NODES     = 1024;
  localparam int LEVELS    = 10;
  localparam int SLOT_W    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TBL_DEPTH = NODES * LEVELS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam logic [LVL_W-1:0]   LAST_LVL  = LVL_W'(LEVELS - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic [TBL_AW-1:0] raddr_a;
    logic [TBL_AW-1:0] raddr_b;
  } tbl_port_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [DEPTH_W-1:0] wdata;
    logic [SLOT_W-1:0]  raddr_a;
    logic [SLOT_W-1:0]  raddr_b;
  } dep_port_t;

  // Reduces a node number to its table row by restoring subtraction.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [NODE_W-1:0] node);
    logic [31:0] r;
    r = 32'(node);
    for (int k = NODE_W - 1; k >= 0; k--) begin
      if (r >= (32'(NODES) << k)) begin
        r = r - (32'(NODES) << k);
      end
    end
    return r[SLOT_W-1:0];
  endfunction

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [NODE_W-1:0] node,
                                                 input logic [LVL_W-1:0]  level);
    return TBL_AW'(slot_of(node)) * TBL_AW'(LEVELS) + TBL_AW'(level);
  endfunction

endpackage

// File: rtl/core/lca_if.sv
// Request and response channel interfaces of the lowest-common-ancestor block.
interface lca_req_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lca_pkg::NODE_W-1:0]  node_a;
  logic [lca_pkg::NODE_W-1:0]  node_b;

  modport source (output valid, kind, node_a, node_b, input ready);
  modport sink (input valid, kind, node_a, node_b, output ready);
endinterface

interface lca_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lca_pkg::NODE_W-1:0]  ancestor_node;

  modport source (output valid, ancestor_node, input ready);
  modport sink (input valid, ancestor_node, output ready);
endinterface

// File: rtl/core/lca_ram.sv
// Generic RAM with one write port and two registered read ports.
module lca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// File: rtl/core/lca_seq.sv
// Sequencer that fills the ancestor table and walks it to answer queries.
module lca_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  lca_pkg::req_t               req_i,
  output lca_pkg::res_t               res_o,
  input  logic                        res_ready_i,
  output lca_pkg::tbl_port_t          tbl_o,
  input  logic [lca_pkg::NODE_W-1:0]  tbl_rdata_a_i,
  input  logic [lca_pkg::NODE_W-1:0]  tbl_rdata_b_i,
  output lca_pkg::dep_port_t          dep_o,
  input  logic [lca_pkg::DEPTH_W-1:0] dep_rdata_a_i,
  input  logic [lca_pkg::DEPTH_W-1:0] dep_rdata_b_i
);
  import lca_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_ADD_DEP, S_ADD_WD, S_FILL_RD, S_FILL_WR, S_Q_DEP, S_Q_DIFF,
    S_LIFT, S_LIFT_WR, S_CMP, S_DESC_RD, S_DESC_CMP, S_FIN_RD, S_FIN_WR, S_DONE
  } state_e;

  state_e             state_q;
  logic [NODE_W-1:0]  u_q;
  logic [NODE_W-1:0]  v_q;
  logic [LVL_W-1:0]   k_q;
  logic [LEVELS-1:0]  diff_q;
  logic [NODE_W-1:0]  res_q;
  logic [LVL_W-1:0]   k_prev;
  logic [DEPTH_W-1:0] dep_diff;

  assign k_prev   = k_q - LVL_W'(1);
  assign dep_diff = (dep_rdata_a_i < dep_rdata_b_i) ? (dep_rdata_b_i - dep_rdata_a_i)
                                                    : (dep_rdata_a_i - dep_rdata_b_i);

  assign req_ready_o = (state_q == S_IDLE);
  assign res_o.valid = (state_q == S_DONE);
  assign res_o.node  = res_q;

  always_comb begin
    tbl_o.we      = 1'b0;
    tbl_o.waddr   = tbl_addr(u_q, k_q);
    tbl_o.wdata   = u_q;
    tbl_o.raddr_a = tbl_addr(u_q, k_q);
    tbl_o.raddr_b = tbl_addr(v_q, k_q);
    dep_o.we      = 1'b0;
    dep_o.waddr   = slot_of(u_q);
    dep_o.wdata   = '0;
    dep_o.raddr_a = slot_of(u_q);
    dep_o.raddr_b = slot_of(v_q);
    case (state_q)
      S_ROOT: begin
        tbl_o.we = 1'b1;
        dep_o.we = 1'b1;
      end
      S_ADD_DEP: begin
        tbl_o.we      = 1'b1;
        tbl_o.waddr   = tbl_addr(u_q, '0);
        tbl_o.wdata   = v_q;
        dep_o.raddr_a = slot_of(v_q);
      end
      S_ADD_WD: begin
        dep_o.we    = 1'b1;
        dep_o.wdata = (dep_rdata_a_i == DEPTH_MAX) ? DEPTH_MAX
                                                   : dep_rdata_a_i + DEPTH_W'(1);
      end
      S_FILL_RD: begin
        tbl_o.raddr_a = tbl_addr(v_q, k_prev);
      end
      S_FILL_WR: begin
        tbl_o.we    = 1'b1;
        tbl_o.wdata = tbl_rdata_a_i;
      end
      S_FIN_RD: begin
        tbl_o.raddr_a = tbl_addr(u_q, '0);
      end
      default: begin
        tbl_o.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      u_q     <= '0;
      v_q     <= '0;
      k_q     <= '0;
      diff_q  <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            u_q <= req_i.node_a;
            v_q <= req_i.node_b;
            k_q <= '0;
            if (req_i.kind == KIND_QUERY) begin
              state_q <= S_Q_DEP;
            end else if (req_i.node_a == req_i.node_b) begin
              state_q <= S_ROOT;
            end else begin
              state_q <= S_ADD_DEP;
            end
          end
        end
        S_ROOT: begin
          if (k_q == LAST_LVL) begin
            state_q <= S_IDLE;
          end else begin
            k_q <= k_q + LVL_W'(1);
          end
        end
        S_ADD_DEP: begin
          state_q <= S_ADD_WD;
        end
        S_ADD_WD: begin
          if (LEVELS == 1) begin
            state_q <= S_IDLE;
          end else begin
            k_q     <= LVL_W'(1);
            state_q <= S_FILL_RD;
          end
        end
        S_FILL_RD: begin
          state_q <= S_FILL_WR;
        end
        S_FILL_WR: begin
          v_q <= tbl_rdata_a_i;
          if (k_q == LAST_LVL) begin
            state_q <= S_IDLE;
          end else begin
            k_q     <= k_q + LVL_W'(1);
            state_q <= S_FILL_RD;
          end
        end
        S_Q_DEP: begin
          state_q <= S_Q_DIFF;
        end
        S_Q_DIFF: begin
          if (dep_rdata_a_i < dep_rdata_b_i) begin
            u_q <= v_q;
            v_q <= u_q;
          end
          diff_q  <= LEVELS'(dep_diff);
          k_q     <= '0;
          state_q <= S_LIFT;
        end
        S_LIFT: begin
          if (diff_q[k_q]) begin
            state_q <= S_LIFT_WR;
          end else if (k_q == LAST_LVL) begin
            state_q <= S_CMP;
          end else begin
            k_q <= k_q + LVL_W'(1);
          end
        end
        S_LIFT_WR: begin
          u_q <= tbl_rdata_a_i;
          if (k_q == LAST_LVL) begin
            state_q <= S_CMP;
          end else begin
            k_q     <= k_q + LVL_W'(1);
            state_q <= S_LIFT;
          end
        end
        S_CMP: begin
          if (u_q == v_q) begin
            res_q   <= u_q;
            state_q <= S_DONE;
          end else begin
            k_q     <= LAST_LVL;
            state_q <= S_DESC_RD;
          end
        end
        S_DESC_RD: begin
          state_q <= S_DESC_CMP;
        end
        S_DESC_CMP: begin
          if (tbl_rdata_a_i != tbl_rdata_b_i) begin
            u_q <= tbl_rdata_a_i;
            v_q <= tbl_rdata_b_i;
          end
          if (k_q == '0) begin
            state_q <= S_FIN_RD;
          end else begin
            k_q     <= k_prev;
            state_q <= S_DESC_RD;
          end
        end
        S_FIN_RD: begin
          state_q <= S_FIN_WR;
        end
        S_FIN_WR: begin
          res_q   <= tbl_rdata_a_i;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/binary_lifting_lca.sv
// Top level of the binary-lifting lowest-common-ancestor block.
//
//   Channel  Direction  Payload                   Request
//   req_i    in         kind, node_a, node_b      add a node or ask a query
//   rsp_o    out        ancestor_node             one per query, none per add
//
// A root add makes one table write per level; a child add makes one table read per level
// whose result addresses the next level.
// A query walks the levels upward, taking the table entry at each set bit of the depth
// difference; if the nodes still differ it compares ancestors per level, then reads a parent.
// Reset needs no clearing pass; the tables hold whatever they held until written.
// A finished result waits in the output register while the next request is taken.
module binary_lifting_lca (
  input  logic      clk_i,
  input  logic      rst_ni,
  lca_req_if.sink   req_i,
  lca_rsp_if.source rsp_o
);
  import lca_pkg::*;

  req_t               req;
  res_t               res;
  logic               res_ready;
  tbl_port_t          tbl;
  dep_port_t          dep;
  logic [NODE_W-1:0]  tbl_rdata_a;
  logic [NODE_W-1:0]  tbl_rdata_b;
  logic [DEPTH_W-1:0] dep_rdata_a;
  logic [DEPTH_W-1:0] dep_rdata_b;
  logic               rsp_valid_q;
  logic [NODE_W-1:0]  rsp_node_q;

  assign req.kind   = req_i.kind;
  assign req.node_a = req_i.node_a;
  assign req.node_b = req_i.node_b;

  lca_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_i         (req),
    .res_o         (res),
    .res_ready_i   (res_ready),
    .tbl_o         (tbl),
    .tbl_rdata_a_i (tbl_rdata_a),
    .tbl_rdata_b_i (tbl_rdata_b),
    .dep_o         (dep),
    .dep_rdata_a_i (dep_rdata_a),
    .dep_rdata_b_i (dep_rdata_b)
  );

  lca_ram #(
    .WIDTH (NODE_W),
    .DEPTH (TBL_DEPTH),
    .AW    (TBL_AW)
  ) u_tbl_ram (
    .clk_i     (clk_i),
    .we_i      (tbl.we),
    .waddr_i   (tbl.waddr),
    .wdata_i   (tbl.wdata),
    .raddr_a_i (tbl.raddr_a),
    .raddr_b_i (tbl.raddr_b),
    .rdata_a_o (tbl_rdata_a),
    .rdata_b_o (tbl_rdata_b)
  );

  lca_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (NODES),
    .AW    (SLOT_W)
  ) u_dep_ram (
    .clk_i     (clk_i),
    .we_i      (dep.we),
    .waddr_i   (dep.waddr),
    .wdata_i   (dep.wdata),
    .raddr_a_i (dep.raddr_a),
    .raddr_b_i (dep.raddr_b),
    .rdata_a_o (dep_rdata_a),
    .rdata_b_o (dep_rdata_b)
  );

  assign res_ready = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res_ready) begin
      rsp_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      rsp_node_q <= res.node;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.ancestor_node = rsp_node_q;

endmodule

// File: rtl/core/lca_checker.sv
// Port-level checks of the lowest-common-ancestor block and their binding.
module lca_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       req_kind_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [lca_pkg::NODE_W-1:0] rsp_node_i
);
  import lca_pkg::*;

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_i)
    else $error("request accepted while the previous one was still in work");

  // A new response is only loaded while the sequencer is holding a result.
  a_rsp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_ready_i))
    else $error("response appeared without a finished query");

  // A query needs its depth reads before its answer can appear.
  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_kind_i == KIND_QUERY) |=> !$rose(rsp_valid_i) ##1 !$rose(rsp_valid_i))
    else $error("query answered too early");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_node_i)))
    else $error("stalled response changed");

endmodule

bind binary_lifting_lca lca_checker u_lca_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_kind_i  (req_i.kind),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_node_i  (rsp_o.ancestor_node)
);

// File: tb/binary_lifting_lca_tb.sv
// Self-checking testbench for binary_lifting_lca: directed and random tree building and ancestor queries.
`timescale 1ns / 100ps

module binary_lifting_lca_tb;
  import lca_pkg::*;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  localparam int CHAIN_LEN = 320;

  typedef struct {
    node_t node_a;
    node_t node_b;
    node_t ancestor;
  } lca_answer_t;

  class lca_scoreboard;
    node_t       up_tab [NODES][LEVELS];
    depth_t      depth_of [NODES];
    lca_answer_t answers_due [$];
    int unsigned fails;
    int unsigned results_seen;

    function new();
      fails = 0;
      results_seen = 0;
    endfunction

    function void graft_node(input node_t node, input node_t parent);
      depth_t pd;
      if (node == parent) begin
        depth_of[node] = '0;
        for (int k = 0; k < LEVELS; k++) begin
          up_tab[node][k] = node;
        end
      end else begin
        pd = depth_of[parent];
        depth_of[node] = (pd == DEPTH_MAX) ? DEPTH_MAX : pd + 1'b1;
        up_tab[node][0] = parent;
        for (int k = 1; k < LEVELS; k++) begin
          up_tab[node][k] = up_tab[up_tab[node][k-1]][k-1];
        end
      end
    endfunction

    function node_t lowest_common(input node_t u, input node_t v);
      depth_t du, dv, gap;
      node_t  t, au, av;
      du = depth_of[u];
      dv = depth_of[v];
      if (du < dv) begin
        t = u;
        u = v;
        v = t;
        gap = dv - du;
      end else begin
        gap = du - dv;
      end
      for (int k = 0; k < LEVELS; k++) begin
        if (gap[k]) begin
          u = up_tab[u][k];
        end
      end
      if (u == v) begin
        return u;
      end
      for (int k = LEVELS - 1; k >= 0; k--) begin
        au = up_tab[u][k];
        av = up_tab[v][k];
        if (au != av) begin
          u = au;
          v = av;
        end
      end
      return up_tab[u][0];
    endfunction

    function void note_request(input logic kind, input node_t a, input node_t b);
      lca_answer_t ans;
      if (kind == KIND_ADD) begin
        graft_node(a, b);
      end else begin
        ans.node_a = a;
        ans.node_b = b;
        ans.ancestor = lowest_common(a, b);
        answers_due = {answers_due, ans};
      end
    endfunction

    task report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fails++;
    endtask

    task check_answer(input node_t got);
      lca_answer_t ans;
      results_seen++;
      if (answers_due.size() == 0) begin
        report($sformatf("ancestor %0d arrived with no query pending", got));
      end else begin
        ans = answers_due.pop_front();
        if (got !== ans.ancestor) begin
          report($sformatf("query (%0d, %0d): ancestor %0d, expected %0d",
                           ans.node_a, ans.node_b, got, ans.ancestor));
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  lca_req_if req ();
  lca_rsp_if rsp ();

  binary_lifting_lca dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #5 clk_i = ~clk_i;

  lca_scoreboard sb;
  bit          quiet = 1'b0;
  int unsigned gap_pct = 0;
  bit          added [NODES];
  node_t       parent_of [NODES];
  node_t       members [$];
  node_t       last_added;

  task automatic send_request(input logic kind, input node_t a, input node_t b);
    req.valid <= 1'b1;
    req.kind <= kind;
    req.node_a <= a;
    req.node_b <= b;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(kind, a, b);
    if (kind == KIND_ADD) begin
      if (!added[a]) begin
        added[a] = 1'b1;
        members = {members, a};
      end
      parent_of[a] = b;
      last_added = a;
    end
    if (!quiet && $urandom_range(99) < gap_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
  endtask

  task automatic random_items(input int unsigned count, input bit tail_quiet);
    int unsigned roll;
    node_t a, b;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      if (tail_quiet && i + 100 >= count) begin
        quiet = 1'b1;
      end
      roll = $urandom_range(99);
      if (members.size() == 0 || roll < 5) begin
        a = node_t'($urandom_range(1023));
        send_request(KIND_ADD, a, a);
      end else if (roll < 45) begin
        a = node_t'($urandom_range(1023));
        b = $urandom_range(1) ? last_added : members[$urandom_range(members.size() - 1)];
        send_request(KIND_ADD, a, b);
      end else begin
        a = members[$urandom_range(members.size() - 1)];
        if (roll < 60) begin
          b = parent_of[a];
        end else if (roll < 67) begin
          b = a;
        end else if (roll < 80) begin
          b = last_added;
        end else begin
          b = members[$urandom_range(members.size() - 1)];
        end
        send_request(KIND_QUERY, a, b);
      end
    end
  endtask

  initial begin : stimulus
    node_t       order [NODES];
    node_t       t;
    int unsigned j;
    int unsigned waited;
    sb = new();
    rst_ni = 1'b0;
    req.valid <= 1'b0;
    req.kind <= KIND_ADD;
    req.node_a <= '0;
    req.node_b <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(KIND_ADD, 10'd0, 10'd0);
    send_request(KIND_ADD, 10'd1023, 10'd0);
    send_request(KIND_ADD, 10'd512, 10'd1023);
    send_request(KIND_ADD, 10'd341, 10'd0);
    send_request(KIND_ADD, 10'd682, 10'd341);
    send_request(KIND_ADD, 10'd5, 10'd5);
    send_request(KIND_ADD, 10'd1, 10'd512);
    send_request(KIND_QUERY, 10'd1, 10'd682);
    send_request(KIND_QUERY, 10'd682, 10'd1);
    send_request(KIND_QUERY, 10'd1, 10'd1023);
    send_request(KIND_QUERY, 10'd1023, 10'd1);
    send_request(KIND_QUERY, 10'd0, 10'd0);
    send_request(KIND_QUERY, 10'd1023, 10'd1023);
    send_request(KIND_QUERY, 10'd1, 10'd5);
    send_request(KIND_QUERY, 10'd5, 10'd5);
    send_request(KIND_QUERY, 10'd512, 10'd341);
    send_request(KIND_ADD, 10'd341, 10'd1);
    send_request(KIND_QUERY, 10'd682, 10'd1);
    send_request(KIND_QUERY, 10'd341, 10'd512);

    random_items(120, 1'b0);

    // A long chain of nodes reaches the deeper lifts and is then closed into a cycle.
    gap_pct = 5;
    for (int i = 0; i < NODES; i++) begin
      order[i] = node_t'(i);
    end
    for (int i = NODES - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    send_request(KIND_ADD, order[0], order[0]);
    for (int i = 1; i < CHAIN_LEN; i++) begin
      send_request(KIND_ADD, order[i], order[i-1]);
    end
    for (int i = 0; i < 30; i++) begin
      send_request(KIND_QUERY, order[$urandom_range(CHAIN_LEN - 1)],
                   order[$urandom_range(CHAIN_LEN - 1)]);
    end
    send_request(KIND_QUERY, order[0], order[CHAIN_LEN-1]);
    send_request(KIND_ADD, order[0], order[CHAIN_LEN-1]);
    send_request(KIND_ADD, order[1], order[0]);
    send_request(KIND_QUERY, order[0], order[CHAIN_LEN-1]);
    send_request(KIND_QUERY, order[1], order[CHAIN_LEN/2]);
    send_request(KIND_QUERY, order[1], order[0]);
    for (int i = 0; i < 5; i++) begin
      send_request(KIND_QUERY, order[$urandom_range(1)], order[$urandom_range(CHAIN_LEN - 1)]);
    end

    random_items(150, 1'b1);
    req.valid <= 1'b0;

    waited = 0;
    while (sb.answers_due.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (sb.answers_due.size() != 0) begin
      sb.report($sformatf("%0d queries never answered", sb.answers_due.size()));
    end
    if (sb.fails == 0) begin
      $display("binary_lifting_lca regression: pass");
    end else begin
      $display("binary_lifting_lca regression: fail");
    end
    $finish;
  end

  initial begin : answer_sink
    int unsigned stall;
    int unsigned stall_pct;
    int unsigned cycle;
    bit          held;
    stall = 0;
    stall_pct = 0;
    cycle = 0;
    held = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (rsp.valid && rsp.ready) begin
        sb.check_answer(rsp.ancestor_node);
      end
      if (cycle % 64 == 0) begin
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      // Hold the response side off long enough for the block to back up into its input.
      if (!held && sb.results_seen == 40) begin
        held = 1'b1;
        stall = 400;
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
        rsp.ready <= 1'b0;
        stall = $urandom_range(12, 1) - 1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("binary_lifting_lca regression: fail");
    $finish;
  end

endmodule
